FILE: src/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;

  localparam int SCREEN_WIDTH_DEF = 84;
  localparam int PAGE_COUNT_DEF   = 6;

  localparam logic [2:0] CMD_WPIX  = 3'd0;
  localparam logic [2:0] CMD_GPIX  = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_BOX   = 3'd3;
  localparam logic [2:0] CMD_FILL  = 3'd4;
  localparam logic [2:0] CMD_CLR   = 3'd5;
  localparam logic [2:0] CMD_RBYTE = 3'd6;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] x_start;
    logic [5:0] y_start;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic [7:0] pixel_value;
    logic [9:0] byte_index;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } out_t;

  // handshake between the command queue and the executor
  typedef struct packed {
    logic valid;
    in_t  cmd;
  } queue_head_t;

endpackage

FILE: src/pfde_front.sv
`timescale 1ns / 1ps
module pfde_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfde_pkg::in_t        in_data,
  input  logic                 open,
  output pfde_pkg::queue_head_t head,
  input  logic                 pop
);

  pfde_pkg::in_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          take;

  // accept only after the frame memory is cleared and while room remains
  assign in_ready = open && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign take     = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];

  // hold commands in a two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      if (push && !take) count <= count + 2'd1;
      else if (!push && take) count <= count - 2'd1;
    end
  end

endmodule

FILE: src/pfde_back.sv
`timescale 1ns / 1ps
module pfde_back #(
  parameter int SCREEN_WIDTH = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = pfde_pkg::PAGE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pfde_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  open,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pfde_pkg::out_t        out_data
);

  localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(FRAME_BYTES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_LSET = 4'd3;
  localparam logic [3:0] S_PIX  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_ADV  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_NEXT = 4'd8;
  localparam logic [3:0] S_GDAT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic [1:0] PM_SET  = 2'd0;
  localparam logic [1:0] PM_CLR  = 2'd1;
  localparam logic [1:0] PM_KEEP = 2'd2;

  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [3:0]    state;
  logic          init_done;
  pfde_pkg::in_t cmd;
  logic [1:0]    pmode;
  logic [1:0]    li;
  logic [5:0]    fy;
  logic [6:0]    lx1, lx2;
  logic [5:0]    ly1, ly2;
  logic          vert;
  logic          neg;
  logic [6:0]    dx;
  logic [5:0]    ady;
  logic [6:0]    cx;
  logic [5:0]    cy;
  logic [5:0]    q;
  logic [7:0]    r;
  logic [AW-1:0] pa;
  logic [7:0]    pbit;
  logic [AW-1:0] caddr;
  logic [7:0]    mask;
  logic          clip;
  logic [7:0]    res_data;

  logic [5:0]    py;
  logic          p_on;
  logic [AW-1:0] p_addr;
  logic          s_on;
  logic [AW-1:0] s_addr;
  logic          idx_ok;

  // current pixel of the walked line
  assign py     = vert ? cy : (neg ? (ly1 - q) : (ly1 + q));
  assign p_on   = ({1'b0, cx} < 8'(SCREEN_WIDTH)) && ({1'b0, py[5:3]} < 4'(PAGE_COUNT));
  assign p_addr = AW'(py[5:3]) * AW'(SCREEN_WIDTH) + AW'(cx);

  // single pixel of get pixel
  assign s_on   = ({1'b0, cmd.x_start} < 8'(SCREEN_WIDTH))
               && ({1'b0, cmd.y_start[5:3]} < 4'(PAGE_COUNT));
  assign s_addr = AW'(cmd.y_start[5:3]) * AW'(SCREEN_WIDTH) + AW'(cmd.x_start);
  assign idx_ok = {1'b0, cmd.byte_index} < 11'(FRAME_BYTES);

  assign open = init_done;
  assign pop  = (state == S_IDLE) && head.valid;

  // drive memory ports from the sequencer state
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pa;
    mem_wd = rd_data;
    mem_re = 1'b0;
    mem_ra = p_addr;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = caddr;
        mem_wd = 8'd0;
      end
      S_PIX: begin
        mem_re = p_on;
      end
      S_WR: begin
        mem_we = 1'b1;
        if (pmode == PM_SET) mem_wd = rd_data | pbit;
        else if (pmode == PM_CLR) mem_wd = rd_data & ~pbit;
      end
      S_DISP: begin
        mem_re = (cmd.command == pfde_pkg::CMD_GPIX) ? s_on : idx_ok;
        mem_ra = (cmd.command == pfde_pkg::CMD_GPIX) ? s_addr : cmd.byte_index[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  // command sequencer and line walker
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      init_done <= 1'b0;
      caddr     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (caddr == AW'(FRAME_BYTES - 1)) begin
            caddr <= '0;
            if (init_done) begin
              state <= S_DONE;
            end else begin
              init_done <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            caddr <= caddr + AW'(1);
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            cmd      <= head.cmd;
            clip     <= 1'b0;
            res_data <= 8'd0;
            pmode    <= PM_SET;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          lx1   <= cmd.x_start;
          ly1   <= cmd.y_start;
          lx2   <= cmd.x_end;
          ly2   <= cmd.y_end;
          li    <= 2'd0;
          fy    <= cmd.y_start;
          state <= S_LSET;
          case (cmd.command)
            pfde_pkg::CMD_WPIX: begin
              lx2 <= cmd.x_start;
              ly2 <= cmd.y_start;
              if (cmd.pixel_value == 8'd1) pmode <= PM_SET;
              else if (cmd.pixel_value == 8'd0) pmode <= PM_CLR;
              else pmode <= PM_KEEP;
            end
            pfde_pkg::CMD_GPIX: begin
              mask <= 8'(1) << cmd.y_start[2:0];
              clip <= !s_on;
              state <= s_on ? S_GDAT : S_DONE;
            end
            pfde_pkg::CMD_LINE: begin
            end
            pfde_pkg::CMD_BOX: begin
              lx2 <= cmd.x_start;
            end
            pfde_pkg::CMD_FILL: begin
              ly2 <= cmd.y_start;
              if (cmd.y_end < cmd.y_start) state <= S_DONE;
            end
            pfde_pkg::CMD_CLR: begin
              caddr <= '0;
              state <= S_CLR;
            end
            pfde_pkg::CMD_RBYTE: begin
              mask  <= 8'hFF;
              clip  <= !idx_ok;
              state <= idx_ok ? S_GDAT : S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_LSET: begin
          vert <= (lx1 == lx2);
          neg  <= (ly2 < ly1);
          dx   <= lx2 - lx1;
          ady  <= (ly2 < ly1) ? (ly1 - ly2) : (ly2 - ly1);
          cx   <= lx1;
          cy   <= ly1;
          q    <= 6'd0;
          r    <= 8'd0;
          if (lx1 == lx2) state <= (ly2 < ly1) ? S_NEXT : S_PIX;
          else state <= (lx2 < lx1) ? S_NEXT : S_PIX;
        end
        S_PIX: begin
          pa   <= p_addr;
          pbit <= 8'(1) << py[2:0];
          if (p_on) begin
            state <= S_WR;
          end else begin
            clip  <= 1'b1;
            state <= S_ADV;
          end
        end
        S_WR: begin
          state <= S_ADV;
        end
        S_ADV: begin
          if (vert) begin
            if (cy == ly2) begin
              state <= S_NEXT;
            end else begin
              cy    <= cy + 6'd1;
              state <= S_PIX;
            end
          end else if (cx == lx2) begin
            state <= S_NEXT;
          end else begin
            cx    <= cx + 7'd1;
            r     <= r + {2'b00, ady};
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // reduce the remainder one divisor at a time
          if (r >= {1'b0, dx}) begin
            r <= r - {1'b0, dx};
            q <= q + 6'd1;
          end else begin
            state <= S_PIX;
          end
        end
        S_NEXT: begin
          state <= S_DONE;
          case (cmd.command)
            pfde_pkg::CMD_BOX: begin
              li    <= li + 2'd1;
              state <= S_LSET;
              case (li)
                2'd0: begin
                  lx1 <= cmd.x_start; ly1 <= cmd.y_start;
                  lx2 <= cmd.x_end;   ly2 <= cmd.y_start;
                end
                2'd1: begin
                  lx1 <= cmd.x_end; ly1 <= cmd.y_start;
                  lx2 <= cmd.x_end; ly2 <= cmd.y_end;
                end
                2'd2: begin
                  lx1 <= cmd.x_start; ly1 <= cmd.y_end;
                  lx2 <= cmd.x_end;   ly2 <= cmd.y_end;
                end
                default: state <= S_DONE;
              endcase
            end
            pfde_pkg::CMD_FILL: begin
              if (fy != cmd.y_end) begin
                fy    <= fy + 6'd1;
                ly1   <= fy + 6'd1;
                ly2   <= fy + 6'd1;
                state <= S_LSET;
              end
            end
            default: begin
            end
          endcase
        end
        S_GDAT: begin
          res_data <= rd_data & mask;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.read_data <= res_data;
            out_data.clipped   <= clip;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (pfde_pkg::in_t)
// out     | output    | out_valid / out_ready| out_data (pfde_pkg::out_t)
//
// One command at a time. A pixel or byte read passes dispatch and read data;
// a pixel write passes dispatch, line setup, pixel read, write, advance and
// next. A stepped line visits pixel read, write (on screen only), advance and
// a divisor step per subtraction for each column; a vertical line visits pixel
// read, write and advance per row. Clear and the pass after reset sweep all
// SCREEN_WIDTH*PAGE_COUNT bytes (504 by default) of frame memory, one byte a
// cycle; in_ready stays low during the reset pass. A two-entry queue takes
// commands while one runs; the output register holds a result until out_ready.
module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = pfde_pkg::PAGE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfde_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pfde_pkg::out_t out_data
);

  pfde_pkg::queue_head_t head;
  logic                  pop;
  logic                  open;

  pfde_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .open     (open),
    .head     (head),
    .pop      (pop)
  );

  pfde_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .open      (open),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/pfde_checker.sv
`timescale 1ns / 1ps
module pfde_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input pfde_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // read data and clipping never both report
  a_clip_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |-> out_data.read_data == 8'd0)
    else $error("clipped result carries data");

  // no transfer right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("channel active right after reset");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/tb_page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
module tb_page_framebuffer_draw_engine;

  localparam int SW   = pfde_pkg::SCREEN_WIDTH_DEF;
  localparam int PC   = pfde_pkg::PAGE_COUNT_DEF;
  localparam int FB   = SW * PC;
  localparam int IN_W = $bits(pfde_pkg::in_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pfde_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pfde_pkg::out_t out_data;

  page_framebuffer_draw_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  pfde_pkg::in_t  cmd_queue[$];
  pfde_pkg::out_t expected_results[$];
  logic [7:0] shadow_fb [0:FB-1];
  int   errors = 0;
  int   phase = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Shadow framebuffer model
  function automatic bit plot_pixel(input int x, input int y, input logic [7:0] mode);
    int a;
    if (x < 0 || y < 0 || x >= SW || (y >> 3) >= PC) return 1'b1;
    a = SW * (y >> 3) + x;
    if (mode == 8'd1) shadow_fb[a] = shadow_fb[a] | (8'd1 << (y & 7));
    else if (mode == 8'd0) shadow_fb[a] = shadow_fb[a] & ~(8'd1 << (y & 7));
    return 1'b0;
  endfunction

  function automatic bit draw_line(input int x1, input int y1, input int x2, input int y2);
    bit c;
    int dx, dy;
    c = 1'b0;
    if (x1 == x2) begin
      for (int y = y1; y <= y2; y++) c |= plot_pixel(x1, y, 8'd1);
    end else begin
      dx = x2 - x1;
      dy = y2 - y1;
      for (int x = x1; x <= x2; x++)
        c |= plot_pixel(x, y1 + (dy * (x - x1)) / dx, 8'd1);
    end
    return c;
  endfunction

  function automatic pfde_pkg::out_t draw_command(input pfde_pkg::in_t d);
    pfde_pkg::out_t r;
    int xs, ys, xe, ye;
    r = '0;
    xs = int'(d.x_start); ys = int'(d.y_start);
    xe = int'(d.x_end);   ye = int'(d.y_end);
    case (d.command)
      pfde_pkg::CMD_WPIX: r.clipped = plot_pixel(xs, ys, d.pixel_value);
      pfde_pkg::CMD_GPIX: begin
        if (xs < SW && (ys >> 3) < PC)
          r.read_data = shadow_fb[SW * (ys >> 3) + xs] & (8'd1 << (ys & 7));
        else
          r.clipped = 1'b1;
      end
      pfde_pkg::CMD_LINE: r.clipped = draw_line(xs, ys, xe, ye);
      pfde_pkg::CMD_BOX: begin
        r.clipped |= draw_line(xs, ys, xs, ye);
        r.clipped |= draw_line(xs, ys, xe, ys);
        r.clipped |= draw_line(xe, ys, xe, ye);
        r.clipped |= draw_line(xs, ye, xe, ye);
      end
      pfde_pkg::CMD_FILL:
        for (int y = ys; y <= ye; y++) r.clipped |= draw_line(xs, y, xe, y);
      pfde_pkg::CMD_CLR: for (int i = 0; i < FB; i++) shadow_fb[i] = 8'd0;
      pfde_pkg::CMD_RBYTE: begin
        if (d.byte_index < FB) r.read_data = shadow_fb[d.byte_index];
        else r.clipped = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pfde_pkg::in_t make_cmd(input logic [2:0] c, input int xs, input int ys,
                                             input int xe, input int ye, input int v,
                                             input int bi);
    pfde_pkg::in_t d;
    d.command = c;
    d.x_start = 7'(xs); d.y_start = 6'(ys); d.x_end = 7'(xe); d.y_end = 6'(ye);
    d.pixel_value = 8'(v); d.byte_index = 10'(bi);
    return d;
  endfunction

  // Random command, mostly small shapes so runs stay short
  function automatic pfde_pkg::in_t random_cmd();
    pfde_pkg::in_t d;
    int k, span;
    d = pfde_pkg::in_t'(IN_W'({$urandom, $urandom}));
    k = $urandom_range(0, 99);
    if (k < 30) begin
      d.command = pfde_pkg::CMD_WPIX;
      if ($urandom_range(0, 9) < 8) d.pixel_value = 8'($urandom_range(0, 1));
    end else if (k < 48) d.command = pfde_pkg::CMD_GPIX;
    else if (k < 60) d.command = pfde_pkg::CMD_RBYTE;
    else if (k < 75) d.command = pfde_pkg::CMD_LINE;
    else if (k < 85) d.command = pfde_pkg::CMD_BOX;
    else if (k < 94) d.command = pfde_pkg::CMD_FILL;
    else if (k < 96) d.command = pfde_pkg::CMD_CLR;
    else d.command = 3'd7;
    if (d.command == pfde_pkg::CMD_RBYTE && $urandom_range(0, 3) != 0)
      d.byte_index = 10'($urandom_range(0, FB - 1));
    if ($urandom_range(0, 3) != 0) begin
      d.x_start = 7'($urandom_range(0, SW + 4));
      d.y_start = 6'($urandom_range(0, 8 * PC + 3));
    end
    if (d.command inside {pfde_pkg::CMD_LINE, pfde_pkg::CMD_BOX, pfde_pkg::CMD_FILL}) begin
      span = ($urandom_range(0, 29) == 0) ? 127 : ((d.command == pfde_pkg::CMD_FILL) ? 6 : 16);
      if ($urandom_range(0, 7) != 0) begin
        d.x_end = 7'(int'(d.x_start) + $urandom_range(0, span));
        d.y_end = 6'(int'(d.y_start) + $urandom_range(0, span));
        if ($urandom_range(0, 3) == 0 && d.y_start >= span)
          d.y_end = 6'(int'(d.y_start) - $urandom_range(0, span));
        if ($urandom_range(0, 9) == 0) d.x_end = d.x_start;
        if (d.x_end < d.x_start) d.x_end = 7'd127;
        if (d.y_end < d.y_start && d.command == pfde_pkg::CMD_FILL) d.y_end = d.y_start;
      end else if (d.command == pfde_pkg::CMD_FILL) begin
        // reversed or wild corners; keep the fill height small
        if (d.y_end > d.y_start + 4) d.y_end = 6'(int'(d.y_start) + $urandom_range(0, 4));
      end
    end
    return d;
  endfunction

  // Driver: offer queued commands, predict each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(draw_command(in_data));
      if (cmd_queue.size() > 0 && !(phase == 0 && $urandom_range(0, 99) < 23)
          && !(phase == 1 && $urandom_range(0, 99) < 45)) begin
        in_valid <= 1'b1;
        in_data <= cmd_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, pace out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          pfde_pkg::out_t e;
          e = expected_results.pop_front();
          if (out_data.read_data !== e.read_data)
            report_mismatch($sformatf("read_data %h expected %h",
                                      out_data.read_data, e.read_data));
          if (out_data.clipped !== e.clipped)
            report_mismatch($sformatf("clipped %b expected %b", out_data.clipped, e.clipped));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_served < hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= 3000;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !((phase == 0 && $urandom_range(0, 99) < 45)
                      || (phase == 1 && $urandom_range(0, 99) < 23));
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < FB; i++) shadow_fb[i] = 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: corners, off-screen, every command, reversed shapes
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, SW - 1, 8 * PC - 1, 0, 0, 1, 1023));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, SW, 5, 127, 63, 1, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, 127, 63, 0, 0, 255, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, 3, 8 * PC, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, 0, 0, 0, 0, 2, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_GPIX, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_GPIX, SW - 1, 8 * PC - 1, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_GPIX, 127, 63, 127, 63, 255, 1023));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_WPIX, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_RBYTE, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_RBYTE, 0, 0, 0, 0, 0, FB - 1));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_RBYTE, 0, 0, 0, 0, 0, FB));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_RBYTE, 0, 0, 0, 0, 0, 1023));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 0, 10, 127, 10, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 5, 0, 5, 63, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 20, 40, 10, 3, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 30, 40, 30, 3, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 10, 45, 30, 2, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_LINE, 40, 0, 43, 47, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_BOX, 50, 20, 60, 30, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_BOX, 70, 30, 60, 20, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_FILL, 80, 44, 90, 50, 0, 0));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_FILL, 10, 30, 20, 25, 0, 0));
    cmd_queue.push_back(make_cmd(3'd7, 1, 1, 1, 1, 1, 1));
    cmd_queue.push_back(make_cmd(pfde_pkg::CMD_CLR, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 280; i++) cmd_queue.push_back(random_cmd());
    hold_requests = 1;
    wait_drained();
    // swapped idling
    phase = 1;
    for (int i = 0; i < 300; i++) cmd_queue.push_back(random_cmd());
    wait_drained();
    // no idling
    phase = 2;
    for (int i = 0; i < 300; i++) cmd_queue.push_back(random_cmd());
    wait_drained();
    repeat (600) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
